>>> rtl/core/timestamp_text_to_epoch_assert.svh
// Assertion macros shared by the timestamp converter modules.
`ifndef TIMESTAMP_TEXT_TO_EPOCH_ASSERT_SVH
`define TIMESTAMP_TEXT_TO_EPOCH_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define TTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define TTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tte_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode table of the timestamp converter.
package tte_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic signed [CFG_DATA_W-1:0] OFFSET_RESET = 17'sd28800;

  // Character codes of the text grammar.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef enum logic [1:0] {
    ZONE_NONE,
    ZONE_UTC,
    ZONE_PLUS,
    ZONE_MINUS
  } zone_t;

  // Channel payloads.
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } tte_in_t;

  typedef struct packed {
    logic signed [38:0] epoch_seconds;
    logic               well_formed;
  } tte_out_t;

  // Fields collected from one text.
  typedef struct packed {
    logic [4:0]  len;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  zone_hour;
    logic [6:0]  zone_minute;
    zone_t       zone_kind;
    logic        bad;
  } fields_t;

  // Datapath operations selected by the control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_CHECK,
    OP_DIV,
    OP_LEAP,
    OP_SETY,
    OP_ERA,
    OP_YOE,
    OP_DOY,
    OP_SCALE,
    OP_TIME,
    OP_ZONE,
    OP_DONE,
    OP_FAIL
  } op_t;

  // Jump conditions.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_REM_GE400,
    COND_CHECK_FAIL,
    COND_LEAP_FAIL
  } cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic fin;
  } ctrl_t;

  typedef struct packed {
    logic rem_ge400;
    logic check_fail;
    logic leap_fail;
  } status_t;

  // Program step addresses.
  localparam logic [PC_W-1:0] STEP_CHECK = 4'd0;
  localparam logic [PC_W-1:0] STEP_DIV_A = 4'd1;
  localparam logic [PC_W-1:0] STEP_LEAP  = 4'd2;
  localparam logic [PC_W-1:0] STEP_SETY  = 4'd3;
  localparam logic [PC_W-1:0] STEP_DIV_B = 4'd4;
  localparam logic [PC_W-1:0] STEP_ERA   = 4'd5;
  localparam logic [PC_W-1:0] STEP_YOE   = 4'd6;
  localparam logic [PC_W-1:0] STEP_DOY   = 4'd7;
  localparam logic [PC_W-1:0] STEP_SCALE = 4'd8;
  localparam logic [PC_W-1:0] STEP_TIME  = 4'd9;
  localparam logic [PC_W-1:0] STEP_ZONE  = 4'd10;
  localparam logic [PC_W-1:0] STEP_DONE  = 4'd11;
  localparam logic [PC_W-1:0] STEP_FAIL  = 4'd12;

  // Microprogram: range checks, year mod 400 for the leap test, then the civil day count.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_CHECK: w = '{op: OP_CHECK, cond: COND_CHECK_FAIL, target: STEP_FAIL,  fin: 1'b0};
      STEP_DIV_A: w = '{op: OP_DIV,   cond: COND_REM_GE400,  target: STEP_DIV_A, fin: 1'b0};
      STEP_LEAP:  w = '{op: OP_LEAP,  cond: COND_LEAP_FAIL,  target: STEP_FAIL,  fin: 1'b0};
      STEP_SETY:  w = '{op: OP_SETY,  cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_DIV_B: w = '{op: OP_DIV,   cond: COND_REM_GE400,  target: STEP_DIV_B, fin: 1'b0};
      STEP_ERA:   w = '{op: OP_ERA,   cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_YOE:   w = '{op: OP_YOE,   cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_DOY:   w = '{op: OP_DOY,   cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_SCALE: w = '{op: OP_SCALE, cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_TIME:  w = '{op: OP_TIME,  cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_ZONE:  w = '{op: OP_ZONE,  cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b0};
      STEP_DONE:  w = '{op: OP_DONE,  cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b1};
      default:    w = '{op: OP_FAIL,  cond: COND_NONE,       target: STEP_FAIL,  fin: 1'b1};
    endcase
    return w;
  endfunction

  // Days from March 1 to the first of the month, in a year that starts in March.
  function automatic logic [8:0] days_before_month(input logic [6:0] month);
    logic [8:0] d;
    case (month)
      7'd3:    d = 9'd0;
      7'd4:    d = 9'd31;
      7'd5:    d = 9'd61;
      7'd6:    d = 9'd92;
      7'd7:    d = 9'd122;
      7'd8:    d = 9'd153;
      7'd9:    d = 9'd184;
      7'd10:   d = 9'd214;
      7'd11:   d = 9'd245;
      7'd12:   d = 9'd275;
      7'd1:    d = 9'd306;
      7'd2:    d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Longest month length, February taken as 29; the leap test trims it later.
  function automatic logic [4:0] month_days_max(input logic [6:0] month);
    logic [4:0] d;
    case (month)
      7'd2:                      d = 5'd29;
      7'd4, 7'd6, 7'd9, 7'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/tte_parse.sv
`timescale 1ns / 1ps
// Character front end: position counter, digit accumulators and syntax checks.
module tte_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  tte_pkg::tte_in_t in_item,
  input  logic             fmt,
  input  logic             clear,
  output tte_pkg::fields_t fields,
  output logic             pend
);
  import tte_pkg::*;

  fields_t    f_r, f_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] c;
  logic       digit;
  logic [3:0] dval;

  // Decimal accumulate, truncated to the accumulator width.
  function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
    logic [10:0] t;
    t = {4'b0, a} * 11'd10 + {7'b0, d};
    return t[6:0];
  endfunction

  function automatic logic [13:0] acc14(input logic [13:0] a, input logic [3:0] d);
    logic [17:0] t;
    t = {4'b0, a} * 18'd10 + {14'b0, d};
    return t[13:0];
  endfunction

  assign c     = in_item.char_code;
  assign digit = (c inside {[CH_ZERO:CH_NINE]});
  assign dval  = c[3:0];

  // Per-character update; the launch of a finished text clears everything.
  always_comb begin
    f_nxt    = f_r;
    pend_nxt = pend_r;
    if (clear) begin
      f_nxt    = '0;
      pend_nxt = 1'b0;
    end else if (accept) begin
      case (f_r.len)
        5'd0, 5'd1, 5'd2, 5'd3: begin
          if (digit) f_nxt.year = acc14(f_r.year, dval);
          else f_nxt.bad = 1'b1;
        end
        5'd4, 5'd7: begin
          if (c != CH_DASH) f_nxt.bad = 1'b1;
        end
        5'd5, 5'd6: begin
          if (digit) f_nxt.month = acc7(f_r.month, dval);
          else f_nxt.bad = 1'b1;
        end
        5'd8, 5'd9: begin
          if (digit) f_nxt.day = acc7(f_r.day, dval);
          else f_nxt.bad = 1'b1;
        end
        5'd10: begin
          if (c != (fmt ? CH_SPACE : CH_T)) f_nxt.bad = 1'b1;
        end
        5'd11, 5'd12: begin
          if (digit) f_nxt.hour = acc7(f_r.hour, dval);
          else f_nxt.bad = 1'b1;
        end
        5'd13, 5'd16: begin
          if (c != CH_COLON) f_nxt.bad = 1'b1;
        end
        5'd14, 5'd15: begin
          if (digit) f_nxt.minute = acc7(f_r.minute, dval);
          else f_nxt.bad = 1'b1;
        end
        5'd17, 5'd18: begin
          if (digit) f_nxt.second = acc7(f_r.second, dval);
          else f_nxt.bad = 1'b1;
        end
        default: begin
          // Zone designator part, present only in the ISO form.
          if (fmt || (f_r.len >= 5'd25)) begin
            f_nxt.bad = 1'b1;
          end else if (f_r.len == 5'd19) begin
            if (c == CH_Z) f_nxt.zone_kind = ZONE_UTC;
            else if (c == CH_PLUS) f_nxt.zone_kind = ZONE_PLUS;
            else if (c == CH_DASH) f_nxt.zone_kind = ZONE_MINUS;
            else f_nxt.bad = 1'b1;
          end else if (f_r.len inside {5'd20, 5'd21}) begin
            if (digit) f_nxt.zone_hour = acc7(f_r.zone_hour, dval);
            else f_nxt.bad = 1'b1;
          end else if (f_r.len == 5'd22) begin
            if (c != CH_COLON) f_nxt.bad = 1'b1;
          end else begin
            if (digit) f_nxt.zone_minute = acc7(f_r.zone_minute, dval);
            else f_nxt.bad = 1'b1;
          end
        end
      endcase
      if (f_r.len != 5'd31) f_nxt.len = f_r.len + 5'd1;
      pend_nxt = in_item.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r    <= '0;
      pend_r <= 1'b0;
    end else begin
      f_r    <= f_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign fields = f_r;
  assign pend   = pend_r;

endmodule

>>> rtl/core/tte_dpath.sv
`timescale 1ns / 1ps
// Datapath driven by the microprogram: field checks, day count and second scaling.
module tte_dpath (
  input  logic                           clk,
  input  logic                           start,
  input  tte_pkg::fields_t               snap_in,
  input  logic                           fmt,
  input  logic signed [tte_pkg::CFG_DATA_W-1:0] offset,
  input  tte_pkg::ctrl_t                 ctrl,
  output tte_pkg::status_t               st,
  output tte_pkg::tte_out_t              result
);
  import tte_pkg::*;

  fields_t            s_r;
  logic               fmt_s_r;
  logic signed [14:0] rem_r, rem_nxt;
  logic signed [5:0]  q_r, q_nxt;
  logic signed [39:0] acc_r, acc_nxt;

  logic               zone_ext, len_bad, zone_bad, range_bad, leap;
  logic [1:0]         hund;
  logic [9:0]         pos;
  logic signed [20:0] doy_term;
  logic [16:0]        tsec;
  logic [15:0]        zoff;
  logic signed [23:0] era_days;
  logic [17:0]        yoe365;
  logic signed [39:0] scaled;

  // Snapshot of one finished text, taken at launch.
  always_ff @(posedge clk) begin
    if (start) begin
      s_r     <= snap_in;
      fmt_s_r <= fmt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    acc_r <= acc_nxt;
  end

  // Length, range and zone checks.
  always_comb begin
    zone_ext = (s_r.zone_kind == ZONE_PLUS) || (s_r.zone_kind == ZONE_MINUS);
    if (fmt_s_r) len_bad = (s_r.len != 5'd19);
    else len_bad = !(((s_r.zone_kind == ZONE_UTC) && (s_r.len == 5'd20)) ||
                     (zone_ext && (s_r.len == 5'd25)));
    zone_bad = !fmt_s_r && zone_ext &&
               ((s_r.zone_hour > 7'd14) || (s_r.zone_minute > 7'd59) ||
                ((s_r.zone_hour == 7'd14) && (s_r.zone_minute != 7'd0)));
    range_bad = (s_r.month < 7'd1) || (s_r.month > 7'd12) || (s_r.day < 7'd1) ||
                (s_r.day > {2'b0, month_days_max(s_r.month)}) ||
                (s_r.hour > 7'd23) || (s_r.minute > 7'd59) || (s_r.second > 7'd59);
  end

  // Leap year from the year remainder mod 400; the low two bits give mod 4.
  assign leap = (s_r.year[1:0] == 2'b00) &&
                !((rem_r == 15'sd100) || (rem_r == 15'sd200) || (rem_r == 15'sd300));

  assign st.rem_ge400  = (rem_r >= 15'sd400);
  assign st.check_fail = s_r.bad || len_bad || range_bad || zone_bad;
  assign st.leap_fail  = (s_r.month == 7'd2) && (s_r.day == 7'd29) && !leap;

  // Centuries within the era, for a remainder below 400.
  always_comb begin
    if (rem_r >= 15'sd300) hund = 2'd3;
    else if (rem_r >= 15'sd200) hund = 2'd2;
    else if (rem_r >= 15'sd100) hund = 2'd1;
    else hund = 2'd0;
  end

  // Operand terms of the individual steps.
  assign pos      = 10'(rem_r[8:2]) + 10'(days_before_month(s_r.month)) + 10'(s_r.day);
  assign doy_term = $signed({11'b0, pos}) - $signed({19'b0, hund}) - 21'sd719469;
  assign tsec     = 17'(s_r.hour) * 17'd3600 + 17'(s_r.minute) * 17'd60 + 17'(s_r.second);
  assign zoff     = 16'(s_r.zone_hour) * 16'd3600 + 16'(s_r.zone_minute) * 16'd60;
  assign era_days = 24'(q_r) * 24'sd146097;
  assign yoe365   = 18'(rem_r[8:0]) * 18'd365;
  assign scaled   = 40'($signed(acc_r[22:0])) * 40'sd86400;

  // One operation per control word.
  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    acc_nxt = acc_r;
    case (ctrl.op)
      OP_CHECK: begin
        rem_nxt = $signed({1'b0, s_r.year});
        q_nxt   = '0;
      end
      OP_DIV: begin
        if (rem_r >= 15'sd400) begin
          rem_nxt = rem_r - 15'sd400;
          q_nxt   = q_r + 6'sd1;
        end
      end
      OP_SETY: begin
        // Years start in March; January and February belong to the year before.
        if (s_r.month <= 7'd2) begin
          if (s_r.year == 14'd0) begin
            rem_nxt = 15'sd399;
            q_nxt   = -6'sd1;
          end else begin
            rem_nxt = $signed({1'b0, s_r.year}) - 15'sd1;
            q_nxt   = '0;
          end
        end else begin
          rem_nxt = $signed({1'b0, s_r.year});
          q_nxt   = '0;
        end
      end
      OP_ERA:   acc_nxt = 40'(era_days);
      OP_YOE:   acc_nxt = acc_r + $signed({22'b0, yoe365});
      OP_DOY:   acc_nxt = acc_r + 40'(doy_term);
      OP_SCALE: acc_nxt = scaled;
      OP_TIME:  acc_nxt = acc_r + $signed({23'b0, tsec});
      OP_ZONE: begin
        if (fmt_s_r) acc_nxt = acc_r - 40'(offset);
        else if (s_r.zone_kind == ZONE_PLUS) acc_nxt = acc_r - $signed({24'b0, zoff});
        else if (s_r.zone_kind == ZONE_MINUS) acc_nxt = acc_r + $signed({24'b0, zoff});
      end
      default: begin
      end
    endcase
  end

  // Result word: the epoch on the good exit, zero on the fail exit.
  assign result.epoch_seconds = (ctrl.op == OP_DONE) ? acc_r[38:0] : '0;
  assign result.well_formed   = (ctrl.op == OP_DONE);

endmodule

>>> rtl/core/tte_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store and conditional jumps.
`include "timestamp_text_to_epoch_assert.svh"
module tte_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  tte_pkg::status_t st,
  output tte_pkg::ctrl_t   ctrl,
  output logic             busy
);
  import tte_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            running_r, running_nxt;
  uword_t          uword;
  logic            take;

  assign uword = ucode_rom(pc_r);

  // Jump condition select.
  always_comb begin
    case (uword.cond)
      COND_REM_GE400:  take = st.rem_ge400;
      COND_CHECK_FAIL: take = st.check_fail;
      COND_LEAP_FAIL:  take = st.leap_fail;
      default:         take = 1'b0;
    endcase
  end

  // Step counter update.
  always_comb begin
    pc_nxt      = pc_r;
    running_nxt = running_r;
    if (start) begin
      pc_nxt      = STEP_CHECK;
      running_nxt = 1'b1;
    end else if (running_r) begin
      if (uword.fin) running_nxt = 1'b0;
      pc_nxt = take ? uword.target : pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= STEP_CHECK;
      running_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      running_r <= running_nxt;
    end
  end

  // Control word to the datapath; idle cycles issue no operation.
  assign ctrl.op  = running_r ? uword.op : OP_NOP;
  assign ctrl.fin = running_r && uword.fin;
  assign busy     = running_r;

  `TTE_ASSERT_NOW(a_start_idle, start, !running_r, "launch while program runs")
  `TTE_ASSERT_NEXT(a_fin_stops, ctrl.fin, !running_r, "program runs past its exit")

endmodule

>>> rtl/core/timestamp_text_to_epoch.sv
`timescale 1ns / 1ps
// Top level of the timestamp text to Unix epoch converter.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    char_code, last_char
//   out_      output     out_valid/out_ready  epoch_seconds, well_formed
//   cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A character request is taken whenever in_ready is high. The request marked last_char
// sets the pending flag; the microprogram launches when it is idle and the previous
// result has been taken. The two passes of the subtract-400 loop reduce the year and y,
// y being the year less one for January and February, before the civil day count.
// Texts that fail a field check exit early through the fail step.
// After a final character the input is held off until the program is free and the
// previous result has been taken; the next text then streams in while the program runs.
// Synchronous reset clears all control state and loads the register reset values.
`include "timestamp_text_to_epoch_assert.svh"
module timestamp_text_to_epoch (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tte_pkg::tte_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tte_pkg::tte_out_t                    out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tte_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import tte_pkg::*;

  logic                         fmt_r, fmt_nxt;
  logic signed [CFG_DATA_W-1:0] offset_r, offset_nxt;
  logic                         out_valid_r, out_valid_nxt;
  tte_out_t                     out_data_r;

  logic     in_accept, pend, busy, start;
  fields_t  fields;
  ctrl_t    ctrl;
  status_t  st;
  tte_out_t result;

  assign in_ready  = !pend;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign start     = pend && !busy && !out_valid_r;

  tte_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_item (in_data),
    .fmt     (fmt_r),
    .clear   (start),
    .fields  (fields),
    .pend    (pend)
  );

  tte_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  tte_dpath u_dpath (
    .clk     (clk),
    .start   (start),
    .snap_in (fields),
    .fmt     (fmt_r),
    .offset  (offset_r),
    .ctrl    (ctrl),
    .st      (st),
    .result  (result)
  );

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    fmt_nxt    = fmt_r;
    offset_nxt = offset_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT: fmt_nxt    = cfg_data[0];
        REG_OFFSET: offset_nxt = $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Output register: loaded at the program exit, freed when the request is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.fin) out_valid_nxt = 1'b1;
    else if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= 1'b0;
      offset_r    <= OFFSET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      fmt_r       <= fmt_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TTE_ASSERT_NOW(a_no_overwrite, ctrl.fin, !out_valid_r, "result overwrites a waiting one")
  `TTE_ASSERT_NOW(a_bad_is_zero, out_valid_r && !out_data_r.well_formed,
                  out_data_r.epoch_seconds == '0, "malformed result carries nonzero epoch")

endmodule

>>> tb/timestamp_text_to_epoch_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the timestamp text to Unix epoch converter.
module timestamp_text_to_epoch_tb;
  import tte_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_CHARS   = 825;
  localparam int PHASE_CHARS    = 150;
  localparam int QUIET_TAIL     = 200;
  localparam int SETTLE_CYCLES  = 80;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  localparam logic FMT_ISO   = 1'b0;
  localparam logic FMT_LOCAL = 1'b1;

  // Indexes past the two defined registers; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef logic [7:0] text_q_t[$];

  // Tracks the converter state, predicts each result and checks it in order.
  class epoch_scoreboard;
    logic               fmt_local;
    logic signed [16:0] local_offset;
    logic [4:0]         pos;
    logic [13:0]        year;
    logic [6:0]         month, day, hour, minute, second, zone_hour, zone_minute;
    zone_t              zone;
    logic               bad;
    tte_out_t           pending_epochs[$];
    int unsigned        mismatches, results_seen, well_formed_seen;

    function new();
      fmt_local = FMT_ISO;
      local_offset = OFFSET_RESET;
      mismatches = 0;
      results_seen = 0;
      well_formed_seen = 0;
      clear_text();
    endfunction

    function void clear_text();
      pos = '0;
      year = '0;
      month = '0;
      day = '0;
      hour = '0;
      minute = '0;
      second = '0;
      zone_hour = '0;
      zone_minute = '0;
      zone = ZONE_NONE;
      bad = 1'b0;
    endfunction

    static function int month_length(int yr, int mo);
      bit leap_year;
      leap_year = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      case (mo)
        2:           return leap_year ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FORMAT: fmt_local = data[0];
        REG_OFFSET: local_offset = data;
        default: ;
      endcase
    endfunction

    // Days since 1970-01-01, counted in 400-year cycles of a March-based year.
    function longint civil_day_count(int yr, int mo, int dy);
      longint shifted_year, cycle400, year_in_cycle, day_in_year;
      shifted_year = longint'(yr) - ((mo <= 2) ? 1 : 0);
      cycle400 = (shifted_year >= 0) ? shifted_year / 400 : -1;
      year_in_cycle = shifted_year - cycle400 * 400;
      day_in_year = (153 * ((mo > 2) ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
      return cycle400 * 146097 + year_in_cycle * 365 + year_in_cycle / 4
             - year_in_cycle / 100 + day_in_year - 719468;
    endfunction

    // Final checks on the collected fields; returns 1 with the epoch when all pass.
    function bit fields_to_epoch(output longint epoch);
      longint zone_shift;
      epoch = 0;
      if (bad) return 1'b0;
      if (fmt_local) begin
        if (pos != 5'd19) return 1'b0;
      end else if (!((zone == ZONE_UTC && pos == 5'd20) ||
                     ((zone == ZONE_PLUS || zone == ZONE_MINUS) && pos == 5'd25))) begin
        return 1'b0;
      end
      if (month < 7'd1 || month > 7'd12 || day < 7'd1) return 1'b0;
      if (day > month_length(year, month) || hour > 7'd23 || minute > 7'd59 ||
          second > 7'd59)
        return 1'b0;
      epoch = civil_day_count(year, month, day) * 86400 + longint'(hour) * 3600
              + longint'(minute) * 60 + longint'(second);
      if (fmt_local) begin
        epoch = epoch - longint'(local_offset);
      end else if (zone != ZONE_UTC) begin
        if (zone_hour > 7'd14 || zone_minute > 7'd59 ||
            (zone_hour == 7'd14 && zone_minute != 7'd0))
          return 1'b0;
        zone_shift = longint'(zone_hour) * 3600 + longint'(zone_minute) * 60;
        epoch = (zone == ZONE_PLUS) ? epoch - zone_shift : epoch + zone_shift;
      end
      return 1'b1;
    endfunction

    // Applies one accepted character; a final character queues the expected result.
    function void note_char(tte_in_t item);
      logic [7:0] c;
      logic       is_digit;
      logic [6:0] dval;
      longint     epoch;
      bit         ok;
      tte_out_t   want;
      c = item.char_code;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      dval = 7'(c - CH_ZERO);
      case (pos)
        5'd0, 5'd1, 5'd2, 5'd3:
          if (is_digit) year = year * 14'd10 + 14'(dval); else bad = 1'b1;
        5'd4, 5'd7:
          if (c != CH_DASH) bad = 1'b1;
        5'd5, 5'd6:
          if (is_digit) month = month * 7'd10 + dval; else bad = 1'b1;
        5'd8, 5'd9:
          if (is_digit) day = day * 7'd10 + dval; else bad = 1'b1;
        5'd10:
          if (c != (fmt_local ? CH_SPACE : CH_T)) bad = 1'b1;
        5'd11, 5'd12:
          if (is_digit) hour = hour * 7'd10 + dval; else bad = 1'b1;
        5'd13, 5'd16:
          if (c != CH_COLON) bad = 1'b1;
        5'd14, 5'd15:
          if (is_digit) minute = minute * 7'd10 + dval; else bad = 1'b1;
        5'd17, 5'd18:
          if (is_digit) second = second * 7'd10 + dval; else bad = 1'b1;
        default: begin
          // Zone designator and offset exist only in the ISO form.
          if (fmt_local || pos >= 5'd25) begin
            bad = 1'b1;
          end else if (pos == 5'd19) begin
            if (c == CH_Z) zone = ZONE_UTC;
            else if (c == CH_PLUS) zone = ZONE_PLUS;
            else if (c == CH_DASH) zone = ZONE_MINUS;
            else bad = 1'b1;
          end else if (pos <= 5'd21) begin
            if (is_digit) zone_hour = zone_hour * 7'd10 + dval; else bad = 1'b1;
          end else if (pos == 5'd22) begin
            if (c != CH_COLON) bad = 1'b1;
          end else begin
            if (is_digit) zone_minute = zone_minute * 7'd10 + dval; else bad = 1'b1;
          end
        end
      endcase
      if (pos != 5'd31) pos = pos + 5'd1;
      if (item.last_char) begin
        ok = fields_to_epoch(epoch);
        want.epoch_seconds = ok ? epoch[38:0] : '0;
        want.well_formed = ok;
        pending_epochs.insert(pending_epochs.size(), want);
        clear_text();
      end
    endfunction

    function void check_result(tte_out_t got);
      tte_out_t want;
      results_seen++;
      if (pending_epochs.size() == 0) begin
        $display("%0t: result with no request pending, got epoch_seconds %0d well_formed %0b",
                 $time, got.epoch_seconds, got.well_formed);
        mismatches++;
        return;
      end
      want = pending_epochs.pop_front();
      if (want.well_formed) well_formed_seen++;
      if (got.epoch_seconds !== want.epoch_seconds) begin
        $display("%0t: epoch_seconds mismatch, expected %0d, got %0d",
                 $time, want.epoch_seconds, got.epoch_seconds);
        mismatches++;
      end
      if (got.well_formed !== want.well_formed) begin
        $display("%0t: well_formed mismatch, expected %0b, got %0b",
                 $time, want.well_formed, got.well_formed);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_epochs.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tte_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tte_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  epoch_scoreboard epoch_check;
  bit          idle_on = 1'b1;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned chars_sent = 0;
  int unsigned texts_sent = 0;
  int unsigned reg_writes = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  timestamp_text_to_epoch dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Offers one character and waits for its request to be taken, then maybe idles.
  task automatic send_char(input logic [7:0] code, input logic last);
    in_valid <= 1'b1;
    in_data  <= '{char_code: code, last_char: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    epoch_check.note_char(in_data);
    chars_sent++;
    if (idle_on && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_text(input text_q_t text, input bit mark_last);
    foreach (text[i]) send_char(text[i], mark_last && (i == text.size() - 1));
    if (mark_last) texts_sent++;
  endtask

  function automatic text_q_t to_bytes(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
    return t;
  endfunction

  task automatic send_stamp(input string s);
    send_text(to_bytes(s), 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    epoch_check.write_register(idx, data);
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stops sending, waits for every expected result, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (epoch_check.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic string zone_suffix(zone_t kind, int zh, int zm);
    if (kind == ZONE_UTC) return "Z";
    return $sformatf("%s%02d:%02d", (kind == ZONE_PLUS) ? "+" : "-", zh, zm);
  endfunction

  function automatic string stamp(int yr, int mo, int dy, int hh, int mi, int ss,
                                  bit local_fmt);
    return $sformatf("%04d-%02d-%02d%s%02d:%02d:%02d", yr, mo, dy,
                     local_fmt ? " " : "T", hh, mi, ss);
  endfunction

  // Mostly valid stamps with random content; the rest carry one kind of fault.
  function automatic text_q_t random_text(logic local_fmt);
    int      yr, mo, dy, hh, mi, ss, zh, zm, kind;
    bit      layout_local;
    zone_t   zk;
    text_q_t t;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0, 1:    yr = $urandom_range(1900, 2100);
      2:       yr = $urandom_range(0, 9999);
      default: yr = $urandom_range(0, 24) * 400 + $urandom_range(0, 3) * 100;
    endcase
    if (yr > 9999) yr = 9999;
    mo = $urandom_range(1, 12);
    dy = ($urandom_range(0, 3) == 0) ? epoch_scoreboard::month_length(yr, mo)
                                     : $urandom_range(1, epoch_scoreboard::month_length(yr, mo));
    hh = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    ss = $urandom_range(0, 59);
    zk = zone_t'($urandom_range(1, 3));
    zh = $urandom_range(0, 14);
    zm = (zh == 14) ? 0 : $urandom_range(0, 59);
    // One field pushed out of its range.
    if (kind >= 70 && kind < 80) begin
      zk = zone_t'($urandom_range(2, 3));
      case ($urandom_range(0, 6))
        0: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        1: dy = $urandom_range(0, 1) ? 0
                : $urandom_range(epoch_scoreboard::month_length(yr, mo) + 1, 99);
        2: hh = $urandom_range(24, 99);
        3: mi = $urandom_range(60, 99);
        4: ss = $urandom_range(60, 99);
        5: zh = $urandom_range(15, 99);
        default: begin
          zh = 14;
          zm = $urandom_range(1, 99);
        end
      endcase
    end
    // A stamp laid out for the other format.
    layout_local = (kind >= 88 && kind < 92) ? !local_fmt : local_fmt;
    t = to_bytes(layout_local ? stamp(yr, mo, dy, hh, mi, ss, 1'b1)
                              : {stamp(yr, mo, dy, hh, mi, ss, 1'b0), zone_suffix(zk, zh, zm)});
    if (kind >= 80 && kind < 88) begin
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom);
    end else if (kind >= 92 && kind < 96) begin
      if ($urandom_range(0, 1)) begin
        t = t[0:$urandom_range(0, t.size() - 2)];
      end else begin
        repeat ($urandom_range(1, 14))
          t.insert(t.size(), $urandom_range(0, 1) ? 8'($urandom_range(CH_ZERO, CH_NINE))
                                                  : 8'($urandom));
      end
    end else if (kind >= 96) begin
      t.delete();
      repeat ($urandom_range(1, 32)) t.insert(t.size(), 8'($urandom));
    end
    return t;
  endfunction

  // Result side: random stalls, one long hold-off on request, and the checks.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) epoch_check.check_result(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run if no request of any channel moves for too long.
  initial begin
    int stalled;
    stalled = 0;
    wait (rst_n === 1'b1);
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus: reset, directed stamps, then random phases under varied settings.
  initial begin
    text_q_t               text;
    int                    random_chars, phase, phase_chars;
    logic [CFG_DATA_W-1:0] reg_value;
    epoch_check = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // ISO form with the reset register values.
    send_stamp("1970-01-01T00:00:00Z");
    send_stamp("9999-12-31T23:59:59-14:00");
    send_stamp("0000-01-01T00:00:00+14:00");
    send_stamp("0000-02-29T00:00:00Z");
    send_stamp("2000-02-29T12:00:00Z");
    send_stamp("1900-02-29T00:00:00Z");
    send_stamp("2023-13-01T00:00:00Z");
    send_stamp("2023-04-31T00:00:00Z");
    send_stamp("2023-06-15T24:00:00Z");
    send_stamp("2023-06-15T12:00:00+14:01");
    send_stamp("2023-06-15T12:00:00+05:30");
    send_stamp("2023-0x-15T12:00:00Z");
    send_stamp("2023/06-15T12:00:00Z");
    send_stamp("2023-06-15T12:00:00+05:300000000000");
    send_stamp("2023-06-15T12:00:00");
    send_stamp("Z");
    send_stamp("2023-06-15 12:00:00");

    // Format switched to local time in the middle of a text.
    send_text(to_bytes("2021-03-04T0"), 1'b0);
    wait_drained();
    write_reg(REG_FORMAT, 17'(FMT_LOCAL));
    send_text(to_bytes("5:06:07"), 1'b1);
    send_stamp("1970-01-01 08:00:00");
    send_stamp("1970-01-01T08:00:00");
    send_stamp("1970-01-01 08:00:00Z");

    // Local form at the offset extremes and beyond the documented range.
    wait_drained();
    write_reg(REG_OFFSET, 17'(-50400));
    send_stamp("9999-12-31 23:59:59");
    wait_drained();
    write_reg(REG_OFFSET, 17'(50400));
    send_stamp("0000-01-01 00:00:00");
    wait_drained();
    write_reg(REG_OFFSET, 17'h10000);
    write_reg(REG_SPARE_A, 17'($urandom));
    write_reg(REG_SPARE_B, 17'($urandom));
    send_stamp("2024-02-29 00:00:00");
    wait_drained();
    write_reg(REG_OFFSET, 17'h0FFFF);
    send_stamp("2100-02-29 00:00:00");
    send_stamp("2400-02-29 23:59:59");

    // Random phases; each one starts from a drained block with new settings.
    random_chars = 0;
    phase = 0;
    while (random_chars < RANDOM_CHARS) begin
      wait_drained();
      reg_value = 17'($urandom);
      reg_value[0] = (phase % 3 == 2) ? 1'($urandom) : 1'(phase % 2);
      write_reg(REG_FORMAT, reg_value);
      case ($urandom_range(0, 5))
        0:       reg_value = 17'(-50400);
        1:       reg_value = 17'(50400);
        2:       reg_value = '0;
        3:       reg_value = 17'(int'($urandom_range(0, 100800)) - 50400);
        4:       reg_value = 17'($urandom);
        default: reg_value = 17'(28800);
      endcase
      write_reg(REG_OFFSET, reg_value);
      idle_on = (RANDOM_CHARS - random_chars > QUIET_TAIL);
      tx_idle_pct = (phase % 4) * 20;
      rx_idle_pct = ((phase + 1) % 4) * 20;
      // One phase runs with the result side held off so the input backs up.
      if (phase == 2) begin
        tx_idle_pct = 0;
        hold_request = 1'b1;
      end
      phase_chars = 0;
      while (phase_chars < PHASE_CHARS) begin
        text = random_text(epoch_check.fmt_local);
        send_text(text, 1'b1);
        phase_chars += text.size();
      end
      random_chars += phase_chars;
      phase++;
    end

    wait_drained();
    $display("Sent %0d characters in %0d texts over %0d phases, %0d register writes.",
             chars_sent, texts_sent, phase, reg_writes);
    $display("Checked %0d results: %0d well-formed, %0d rejected.",
             epoch_check.results_seen, epoch_check.well_formed_seen,
             epoch_check.results_seen - epoch_check.well_formed_seen);
    if (epoch_check.mismatches == 0 && epoch_check.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/tte_pkg.sv
rtl/core/tte_parse.sv
rtl/core/tte_dpath.sv
rtl/core/tte_seq.sv
rtl/core/timestamp_text_to_epoch.sv
tb/timestamp_text_to_epoch_tb.sv
